// ===== rtl/b2s_pkg.sv =====
// ----------------------------------------------------------------------------
// b2s_pkg
// Types and constants used by the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package b2s_pkg;

	typedef enum logic [3:0] {
		S_IDLE, S_BYTE, S_PAD, S_INIT, S_RDA, S_RDC, S_H1, S_H2,
		S_WA, S_WB, S_WC, S_WD, S_FIN, S_OUT
	} state_t;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam logic [31:0] PARAM_WORD = 32'h0101_0000;
	localparam logic        REG_DIGEST_LENGTH = 1'b0;
	localparam logic        REG_PERSONALIZATION = 1'b1;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

endpackage
`default_nettype wire

// ===== rtl/b2s_if.sv =====
// ----------------------------------------------------------------------------
// b2s channels
// Message, digest and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface b2s_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        end_of_message;
	modport source (output valid, data_word, byte_count, end_of_message, input ready);
	modport sink (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface b2s_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_bytes;
	logic        last_word;
	modport source (output valid, digest_word, digest_bytes, last_word, input ready);
	modport sink (input valid, digest_word, digest_bytes, last_word, output ready);
endinterface

interface b2s_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/blake2s_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// blake2s_stream_hasher_top
// Unkeyed BLAKE2s (256-bit digest by default) over a stream of little-endian message words.
// ----------------------------------------------------------------------------
// A request of up to four bytes is appended byte by byte; a request that
// fills past a full block first runs a compression, and the final request pads
// the block and runs the last one. A compression loads the sixteen words of
// the work vector, runs 80 mixing steps (the work vector memory has two read
// ports and one write port, so each step reads in S_RDA and S_RDC, mixes in
// S_H1 and S_H2 and writes back in S_WA to S_WD) and folds it into the
// eight chain words. Digest words then leave one per cycle while taken.
`default_nettype none
module blake2s_stream_hasher_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b2s_msg_if.sink    msg,
	b2s_dig_if.source  dig,
	b2s_cfg_if.sink    cfg
);
	import b2s_pkg::*;

	state_t state_q, state_d;

	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        eom_q;
	logic [2:0]  bidx_q;
	logic        in_msg_q;
	logic [6:0]  fill_q;
	logic [31:0] stage_q;
	logic [4:0]  pidx_q;
	logic [63:0] bcnt_q;
	logic        final_q;
	logic [3:0]  ctr_q;
	logic [2:0]  g_q;
	logic [3:0]  round_q;
	logic [2:0]  oidx_q;
	logic [31:0] h_q [8];
	logic [5:0]  dl_q;
	logic [63:0] pers_q;
	logic [31:0] a_q, b_q, x_q, y_q;
	logic [31:0] a_s1, b_s1, c_s1, d_s1, y_s1;
	logic [31:0] a_s2, b_s2, c_s2, d_s2;

	logic [31:0] v_mem [16];
	logic [31:0] m_mem [16];
	logic [31:0] v_rd0, v_rd1, m_rd0, m_rd1;
	logic [3:0]  v_ra0, v_ra1, m_ra0, m_ra1;
	logic        v_we, m_we;
	logic [3:0]  v_wa, m_wa;
	logic [31:0] v_wd, m_wd;

	logic        msg_acc;
	logic [5:0]  len;
	logic [3:0]  nwords;
	logic [5:0]  nb_raw;
	logic [2:0]  nb;
	logic [31:0] out_word;
	logic        out_last;
	logic [7:0]  cur_byte;
	logic [31:0] new_stage;
	logic [3:0]  ga, gb, gc, gd;
	logic [1:0]  gj, gs;
	logic [31:0] iv_x;
	logic [31:0] t_a1, t_d1, t_c1, t_b1, t_a2, t_d2, t_c2, t_b2;

	assign msg_acc = msg.valid && msg.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		len = dl_q;
		if (dl_q == 6'd0) len = 6'd1;
		else if (dl_q > 6'd32) len = 6'd32;
	end
	assign nwords = 4'(({1'b0, len} + 7'd3) >> 2);
	assign nb_raw = len - {1'b0, oidx_q, 2'b00};
	assign nb = (nb_raw > 6'd4) ? 3'd4 : nb_raw[2:0];
	assign out_last = ({1'b0, oidx_q} + 4'd1) == nwords;
	always_comb begin
		unique case (nb)
			3'd1: out_word = {24'd0, h_q[oidx_q][7:0]};
			3'd2: out_word = {16'd0, h_q[oidx_q][15:0]};
			3'd3: out_word = {8'd0, h_q[oidx_q][23:0]};
			default: out_word = h_q[oidx_q];
		endcase
	end
	assign dig.digest_word = out_word;
	assign dig.digest_bytes = nb;
	assign dig.last_word = out_last;

	// byte append
	assign cur_byte = word_q[{bidx_q[1:0], 3'b000} +: 8];
	assign new_stage = stage_q | ({24'd0, cur_byte} << {fill_q[1:0], 3'b000});

	// mixing step indices: columns, then diagonals
	assign gj = g_q[1:0];
	assign gs = {1'b0, g_q[2]};
	assign ga = {2'b00, gj};
	assign gb = {2'b01, gj + gs};
	assign gc = {2'b10, gj + 2'(gs << 1)};
	assign gd = {2'b11, gj + 2'(gs * 2'd3)};

	assign t_a1 = a_q + b_q + x_q;
	assign t_d1 = v_rd1 ^ t_a1;
	assign t_c1 = v_rd0 + {t_d1[15:0], t_d1[31:16]};
	assign t_b1 = b_q ^ t_c1;

	assign t_a2 = a_s1 + b_s1 + y_s1;
	assign t_d2 = d_s1 ^ t_a2;
	assign t_c2 = c_s1 + {t_d2[7:0], t_d2[31:8]};
	assign t_b2 = b_s1 ^ t_c2;

	always_comb begin
		iv_x = IV[ctr_q[2:0]];
		unique case (ctr_q[2:0])
			3'd4: iv_x = IV[4] ^ bcnt_q[31:0];
			3'd5: iv_x = IV[5] ^ bcnt_q[63:32];
			3'd6: iv_x = final_q ? ~IV[6] : IV[6];
			default: iv_x = IV[ctr_q[2:0]];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (msg_acc) state_d = S_BYTE;
			S_BYTE: begin
				if (bidx_q == cnt_q) state_d = eom_q ? S_PAD : S_IDLE;
				else if (fill_q == 7'(BLOCK_BYTES)) state_d = S_INIT;
			end
			S_PAD: if (pidx_q == 5'd16) state_d = S_INIT;
			S_INIT: if (ctr_q == 4'd15) state_d = S_RDA;
			S_RDA: state_d = S_RDC;
			S_RDC: state_d = S_H1;
			S_H1: state_d = S_H2;
			S_H2: state_d = S_WA;
			S_WA: state_d = S_WB;
			S_WB: state_d = S_WC;
			S_WC: state_d = S_WD;
			S_WD: state_d = (g_q == 3'd7 && round_q == 4'd9) ? S_FIN : S_RDA;
			S_FIN: if (ctr_q == 4'd8) state_d = final_q ? S_OUT : S_BYTE;
			S_OUT: if (dig.ready && out_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		msg.ready = (state_q == S_IDLE);
		dig.valid = (state_q == S_OUT);
	end

	// memory ports
	always_comb begin
		v_ra0 = ga;
		v_ra1 = gb;
		unique case (state_q)
			S_RDC: begin
				v_ra0 = gc;
				v_ra1 = gd;
			end
			S_FIN: begin
				v_ra0 = {1'b0, ctr_q[2:0]};
				v_ra1 = {1'b1, ctr_q[2:0]};
			end
			default: begin
				v_ra0 = ga;
				v_ra1 = gb;
			end
		endcase
		m_ra0 = SIGMA[round_q][{g_q, 1'b0}];
		m_ra1 = SIGMA[round_q][{g_q, 1'b1}];

		v_we = 1'b0;
		v_wa = ga;
		v_wd = a_s2;
		unique case (state_q)
			S_INIT: begin
				v_we = 1'b1;
				v_wa = ctr_q;
				v_wd = ctr_q[3] ? iv_x : h_q[ctr_q[2:0]];
			end
			S_WA: begin
				v_we = 1'b1;
				v_wa = ga;
				v_wd = a_s2;
			end
			S_WB: begin
				v_we = 1'b1;
				v_wa = gb;
				v_wd = b_s2;
			end
			S_WC: begin
				v_we = 1'b1;
				v_wa = gc;
				v_wd = c_s2;
			end
			S_WD: begin
				v_we = 1'b1;
				v_wa = gd;
				v_wd = d_s2;
			end
			default: v_we = 1'b0;
		endcase

		m_we = 1'b0;
		m_wa = fill_q[5:2];
		m_wd = new_stage;
		if (state_q == S_BYTE && bidx_q != cnt_q && fill_q != 7'(BLOCK_BYTES)
				&& fill_q[1:0] == 2'd3) begin
			m_we = 1'b1;
		end else if (state_q == S_PAD && pidx_q != 5'd16) begin
			m_we = 1'b1;
			m_wa = pidx_q[3:0];
			m_wd = stage_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) v_mem[v_wa] <= v_wd;
		v_rd0 <= v_mem[v_ra0];
		v_rd1 <= v_mem[v_ra1];
	end

	always_ff @(posedge clk) begin
		if (m_we) m_mem[m_wa] <= m_wd;
		m_rd0 <= m_mem[m_ra0];
		m_rd1 <= m_mem[m_ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dl_q <= 6'd32;
			pers_q <= 64'd0;
			in_msg_q <= 1'b0;
			fill_q <= 7'd0;
			bcnt_q <= 64'd0;
			bidx_q <= 3'd0;
			cnt_q <= 3'd0;
			eom_q <= 1'b0;
			final_q <= 1'b0;
			ctr_q <= 4'd0;
			g_q <= 3'd0;
			round_q <= 4'd0;
			oidx_q <= 3'd0;
			pidx_q <= 5'd0;
			stage_q <= 32'd0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_DIGEST_LENGTH: dl_q <= cfg.data[5:0];
					REG_PERSONALIZATION: pers_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (msg_acc) begin
					cnt_q <= (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
					eom_q <= msg.end_of_message;
					bidx_q <= 3'd0;
					if (!in_msg_q) begin
						in_msg_q <= 1'b1;
						fill_q <= 7'd0;
						bcnt_q <= 64'd0;
						stage_q <= 32'd0;
					end
				end
				S_BYTE: begin
					if (bidx_q == cnt_q) begin
						if (eom_q) begin
							bcnt_q <= bcnt_q + {57'd0, fill_q};
							pidx_q <= (fill_q[1:0] != 2'd0) ? fill_q[6:2] :
								5'(({1'b0, fill_q} + 8'd3) >> 2);
						end
					end else if (fill_q == 7'(BLOCK_BYTES)) begin
						bcnt_q <= bcnt_q + 64'(BLOCK_BYTES);
						final_q <= 1'b0;
						ctr_q <= 4'd0;
					end else begin
						fill_q <= fill_q + 7'd1;
						bidx_q <= bidx_q + 3'd1;
						stage_q <= (fill_q[1:0] == 2'd3) ? 32'd0 : new_stage;
					end
				end
				S_PAD: begin
					if (pidx_q == 5'd16) begin
						final_q <= 1'b1;
						ctr_q <= 4'd0;
					end else begin
						pidx_q <= pidx_q + 5'd1;
						stage_q <= 32'd0;
					end
				end
				S_INIT: begin
					ctr_q <= ctr_q + 4'd1;
					g_q <= 3'd0;
					round_q <= 4'd0;
				end
				S_WD: begin
					g_q <= g_q + 3'd1;
					ctr_q <= 4'd0;
					if (g_q == 3'd7 && round_q != 4'd9) round_q <= round_q + 4'd1;
				end
				S_FIN: begin
					ctr_q <= ctr_q + 4'd1;
					if (ctr_q == 4'd8) begin
						fill_q <= 7'd0;
						oidx_q <= 3'd0;
						if (final_q) begin
							in_msg_q <= 1'b0;
							bcnt_q <= 64'd0;
						end
					end
				end
				S_OUT: if (dig.ready) oidx_q <= oidx_q + 3'd1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && msg_acc) begin
			word_q <= msg.data_word;
			if (!in_msg_q) begin
				h_q[0] <= IV[0] ^ PARAM_WORD ^ {26'd0, len};
				for (int i = 1; i < 6; i++) h_q[i] <= IV[i];
				h_q[6] <= IV[6] ^ pers_q[31:0];
				h_q[7] <= IV[7] ^ pers_q[63:32];
			end
		end
		if (state_q == S_FIN && ctr_q != 4'd0) begin
			h_q[3'(ctr_q - 4'd1)] <= h_q[3'(ctr_q - 4'd1)] ^ v_rd0 ^ v_rd1;
		end
		if (state_q == S_RDC) begin
			a_q <= v_rd0;
			b_q <= v_rd1;
			x_q <= m_rd0;
			y_q <= m_rd1;
		end
		if (state_q == S_H1) begin
			a_s1 <= t_a1;
			d_s1 <= {t_d1[15:0], t_d1[31:16]};
			c_s1 <= t_c1;
			b_s1 <= {t_b1[11:0], t_b1[31:12]};
			y_s1 <= y_q;
		end
		if (state_q == S_H2) begin
			a_s2 <= t_a2;
			d_s2 <= {t_d2[7:0], t_d2[31:8]};
			c_s2 <= t_c2;
			b_s2 <= {t_b2[6:0], t_b2[31:7]};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/b2s_checker.sv =====
// ----------------------------------------------------------------------------
// b2s_port_props
// Port-level checks on the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module b2s_port_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        msg_ready,
	input wire logic        dig_valid,
	input wire logic        dig_ready,
	input wire logic [31:0] dig_word,
	input wire logic [2:0]  dig_bytes,
	input wire logic        dig_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid)
		else $error("digest request dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> $stable(dig_word) && $stable(dig_last))
		else $error("digest payload changed while stalled");

	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_last |-> dig_bytes == 3'd4)
		else $error("short digest word before the last one");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !msg_ready)
		else $error("message taken while digest pending");
endmodule

bind blake2s_stream_hasher_top b2s_port_props u_b2s_port_props (
	.clk(clk), .arst_n(arst_n), .msg_ready(msg.ready), .dig_valid(dig.valid),
	.dig_ready(dig.ready), .dig_word(dig.digest_word),
	.dig_bytes(dig.digest_bytes), .dig_last(dig.last_word)
);
`default_nettype wire
